// ===== sv/dlts_pkg.sv =====
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and codes of the delta list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

  // Item kinds
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_TICK     = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [15:0] start_delay;
    logic [15:0] period;
  } in_t;

  typedef struct packed {
    logic       ran;
    logic [7:0] run_id;
    logic [3:0] slot;
    logic       full_res;
  } out_t;

endpackage

// ===== sv/dlts_ram.sv =====
// ----------------------------------------------------------------------------
// dlts_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dlts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/delta_list_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Timer queue kept as a delta list in one entry memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item gives
// exactly one result, shown for one cycle with out_valid high. The receiver
// cannot stall, so sample out_data whenever out_valid is high. A rejected
// add, an empty-list tick or dispatch and an unknown kind are answered
// straight from idle. A tick on a live list reads the head and writes it
// back, and a dispatch on a live list that finds nothing due or removes a
// one-shot head is answered from the dispatch state. An add that lands in
// front of a live entry walks the list one entry a cycle up to and including
// the insertion point; the shift starts with a setup step, moves one entry a
// cycle from the tail down to it and ends with a drain step, and then the new
// entry is written. An add that appends moves nothing in the shift stage.
// All of it runs through the single read and single write port of the entry
// memory. A dispatch of a periodic task removes the head and then makes the
// same insertion. busy drops in the cycle that shows the result, so the next
// item can go in at the edge that takes it. The list lives in a circular
// buffer, so removing the head only advances a pointer. No clearing pass is
// needed after reset: only entries below the live count are used.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler
  import dlts_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int DELAY_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int AW   = $clog2(MAX_TASKS);
  localparam int IDXW = $clog2(MAX_TASKS + 1);
  localparam int CW   = (DELAY_BITS > 16) ? DELAY_BITS : 16;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_DISP  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_INS   = 3'd5;

  typedef struct packed {
    logic [7:0]            id;
    logic [DELAY_BITS-1:0] delta;
    logic [DELAY_BITS-1:0] period;
    logic [7:0]            pending;
  } entry_t;

  // Map a list position to a memory address around the head pointer.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                         input logic [IDXW-1:0] l);
    logic [IDXW:0] s;
    s = (IDXW+1)'(h) + (IDXW+1)'(l);
    if (s >= (IDXW+1)'(MAX_TASKS)) begin
      s = s - (IDXW+1)'(MAX_TASKS);
    end
    return AW'(s);
  endfunction

  // Saturate a 16-bit input delay to the delay width.
  function automatic logic [DELAY_BITS-1:0] clamp_delay(input logic [15:0] v);
    logic [CW-1:0] ext;
    logic [CW-1:0] lim;
    ext = CW'(v);
    lim = CW'({DELAY_BITS{1'b1}});
    if (ext > lim) begin
      return {DELAY_BITS{1'b1}};
    end
    return DELAY_BITS'(ext);
  endfunction

  // Control state
  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] count_r, count_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            pend_r, pend_nxt;

  // Working registers of the item in flight
  logic [IDXW-1:0]       chk_r, chk_nxt;     // position under compare in the walk
  logic [IDXW-1:0]       idx_r, idx_nxt;     // insertion position
  logic [IDXW-1:0]       sh_r, sh_nxt;       // one above the next position to read in the shift
  logic [IDXW-1:0]       src_r, src_nxt;     // position of the entry in rdata
  logic [DELAY_BITS-1:0] dly_r, dly_nxt;     // remaining delay of the new entry
  logic [DELAY_BITS-1:0] per_r, per_nxt;
  logic [7:0]            id_r, id_nxt;
  logic                  reins_r, reins_nxt; // insertion is a periodic re-add
  out_t                  out_data_r, out_data_nxt;

  // Memory port
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  entry_t           wdata, q;
  logic [$bits(entry_t)-1:0] rdata;

  assign q = entry_t'(rdata);

  dlts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    out_valid_nxt = 1'b0;
    pend_nxt      = pend_r;
    chk_nxt       = chk_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    src_nxt       = src_r;
    dly_nxt       = dly_r;
    per_nxt       = per_r;
    id_nxt        = id_r;
    reins_nxt     = reins_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = head_r;
    wdata         = q;
    raddr         = phys(head_r, '0);

    case (state_r)
      ST_IDLE: begin
        // The head is read every idle cycle, so its data is ready next cycle.
        if (start) begin
          out_data_nxt = '0;
          case (in_data.kind)
            KIND_ADD: begin
              if (count_r == IDXW'(MAX_TASKS)) begin
                out_data_nxt.full_res = 1'b1;
                out_valid_nxt         = 1'b1;
              end else begin
                id_nxt    = in_data.task_id;
                dly_nxt   = clamp_delay(in_data.start_delay);
                per_nxt   = clamp_delay(in_data.period);
                reins_nxt = 1'b0;
                chk_nxt   = '0;
                if (count_r == '0) begin
                  idx_nxt   = '0;
                  sh_nxt    = '0;
                  pend_nxt  = 1'b0;
                  state_nxt = ST_SHIFT;
                end else begin
                  state_nxt = ST_WALK;
                end
              end
            end
            KIND_TICK: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_TICK;
              end
            end
            KIND_DISPATCH: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_DISP;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_TICK: begin
        // Count down the head; at zero, raise pending and reload if periodic.
        we    = 1'b1;
        waddr = head_r;
        wdata = q;
        if (q.delta == '0) begin
          if (q.pending != 8'hFF) begin
            wdata.pending = q.pending + 8'd1;
          end
          if (q.period != '0) begin
            wdata.delta = q.period;
          end
        end else begin
          wdata.delta = q.delta - DELAY_BITS'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_DISP: begin
        // Read the entry after the head so a re-add can start its walk.
        raddr = phys(head_r, IDXW'(1));
        if (q.pending == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          out_data_nxt.ran    = 1'b1;
          out_data_nxt.run_id = q.id;
          head_nxt            = phys(head_r, IDXW'(1));
          count_nxt           = count_r - IDXW'(1);
          if (q.period == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            id_nxt    = q.id;
            dly_nxt   = q.delta;
            per_nxt   = q.period;
            reins_nxt = 1'b1;
            chk_nxt   = '0;
            if (count_r == IDXW'(1)) begin
              idx_nxt   = '0;
              sh_nxt    = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SHIFT;
            end else begin
              state_nxt = ST_WALK;
            end
          end
        end
      end

      ST_WALK: begin
        // Pass entries due no later than the new one; prefetch the next.
        raddr = phys(head_r, chk_r + IDXW'(1));
        if (q.delta <= dly_r) begin
          dly_nxt = dly_r - q.delta;
          if (chk_r + IDXW'(1) == count_r) begin
            idx_nxt   = count_r;
            sh_nxt    = count_r;
            pend_nxt  = 1'b0;
            state_nxt = ST_SHIFT;
          end else begin
            chk_nxt = chk_r + IDXW'(1);
          end
        end else begin
          idx_nxt   = chk_r;
          sh_nxt    = count_r;
          pend_nxt  = 1'b0;
          state_nxt = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // Move entries up by one from the tail down to the insertion point.
        raddr = phys(head_r, sh_r - IDXW'(1));
        if (pend_r) begin
          we    = 1'b1;
          waddr = phys(head_r, src_r + IDXW'(1));
          wdata = q;
          if (src_r == idx_r) begin
            wdata.delta = q.delta - dly_r;
          end
        end
        if (sh_r > idx_r) begin
          sh_nxt   = sh_r - IDXW'(1);
          src_nxt  = sh_r - IDXW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_INS;
          end
        end
      end

      ST_INS: begin
        we            = 1'b1;
        waddr         = phys(head_r, idx_r);
        wdata.id      = id_r;
        wdata.delta   = dly_r;
        wdata.period  = per_r;
        wdata.pending = '0;
        count_nxt     = count_r + IDXW'(1);
        if (!reins_r) begin
          out_data_nxt.slot = 4'(idx_r);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    idx_r      <= idx_nxt;
    sh_r       <= sh_nxt;
    src_r      <= src_nxt;
    dly_r      <= dly_nxt;
    per_r      <= per_nxt;
    id_r       <= id_nxt;
    reins_r    <= reins_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/sched_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sched_scoreboard
// Watches both channels of the scheduler, keeps its own copy of the delta
// list, predicts the answer to every transfer it sees go in and compares
// each answer that comes out against the oldest prediction.
// ----------------------------------------------------------------------------
module sched_scoreboard
  import dlts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   mismatches,
  output int   awaited
);

  // Shadow copy of the timer list, head at index 0
  logic [7:0]  tq_id    [MAX_TASKS];
  logic [15:0] tq_delta [MAX_TASKS];
  logic [15:0] tq_per   [MAX_TASKS];
  logic [7:0]  tq_pend  [MAX_TASKS];
  int          live_cnt;

  out_t sched_answers[$];

  // Walk the list, subtracting deltas passed; return the slot or -1 when full.
  function automatic int place_task(logic [7:0] id, logic [15:0] delay,
                                    logic [15:0] per);
    int          idx = 0;
    logic [15:0] rem = delay;
    if (live_cnt >= MAX_TASKS) return -1;
    while (idx < live_cnt && tq_delta[idx] <= rem) begin
      rem -= tq_delta[idx];
      idx++;
    end
    for (int i = live_cnt; i > idx; i--) begin
      tq_id[i]    = tq_id[i-1];
      tq_delta[i] = tq_delta[i-1];
      tq_per[i]   = tq_per[i-1];
      tq_pend[i]  = tq_pend[i-1];
    end
    tq_id[idx]    = id;
    tq_delta[idx] = rem;
    tq_per[idx]   = per;
    tq_pend[idx]  = '0;
    live_cnt++;
    // only the follower is rebased on the new entry
    if (idx + 1 < live_cnt) tq_delta[idx+1] -= rem;
    return idx;
  endfunction

  function automatic out_t step_timer_list(in_t it);
    out_t        res;
    int          s;
    logic [7:0]  hid;
    logic [15:0] hdelta;
    logic [15:0] hper;
    res = '0;
    case (it.kind)
      KIND_ADD: begin
        s = place_task(it.task_id, it.start_delay, it.period);
        if (s < 0) res.full_res = 1'b1;
        else       res.slot     = s[3:0];
      end
      KIND_TICK: begin
        if (live_cnt > 0) begin
          if (tq_delta[0] == '0) begin
            if (tq_pend[0] != 8'hFF) tq_pend[0]++;
            if (tq_per[0] != '0) tq_delta[0] = tq_per[0];
          end else begin
            tq_delta[0]--;
          end
        end
      end
      KIND_DISPATCH: begin
        if (live_cnt > 0 && tq_pend[0] != '0) begin
          hid    = tq_id[0];
          hdelta = tq_delta[0];
          hper   = tq_per[0];
          res.ran    = 1'b1;
          res.run_id = hid;
          // drop the head together with any extra runs it still held
          for (int i = 0; i + 1 < live_cnt; i++) begin
            tq_id[i]    = tq_id[i+1];
            tq_delta[i] = tq_delta[i+1];
            tq_per[i]   = tq_per[i+1];
            tq_pend[i]  = tq_pend[i+1];
          end
          live_cnt--;
          if (hper != '0) void'(place_task(hid, hdelta, hper));
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      sched_answers.delete();
      live_cnt = 0;
      awaited <= 0;
    end else begin
      // retire the answer first: it always belongs to an older transfer
      if (out_valid) begin
        if (sched_answers.size() == 0) begin
          $display("%0t ns: unexpected answer, expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = sched_answers.pop_front();
          compare_field("ran",      8'(want.ran),      8'(out_data.ran));
          compare_field("run_id",   want.run_id,       out_data.run_id);
          compare_field("slot",     8'(want.slot),     8'(out_data.slot));
          compare_field("full_res", 8'(want.full_res), 8'(out_data.full_res));
        end
      end
      if (start && !busy) sched_answers.push_back(step_timer_list(in_data));
      awaited <= sched_answers.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the delta list task scheduler.
// ----------------------------------------------------------------------------
// A directed opening covers the empty list, a kind the block ignores, a head
// with nothing due, the largest delay and period, a full list and the
// pending count saturating under a long burst of ticks. Random traffic
// follows, mostly small delays and one-shot tasks so that heads come due and
// get dispatched, with a few periodic and far-off tasks mixed in. The
// scoreboard beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_top
  import dlts_pkg::*;
();

  localparam int         MAX_TASKS  = 16;
  localparam int         RAND_ITEMS = 160;
  // the one code the block ignores
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   mismatches;
  int   awaited;

  delta_list_task_scheduler #(
    .MAX_TASKS  (MAX_TASKS),
    .DELAY_BITS (16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  sched_scoreboard #(
    .MAX_TASKS (MAX_TASKS)
  ) u_sb (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_t make_item(logic [1:0] kind, logic [7:0] id,
                                    logic [15:0] dly, logic [15:0] per);
    in_t it;
    it.kind        = kind;
    it.task_id     = id;
    it.start_delay = dly;
    it.period      = per;
    return it;
  endfunction

  // Random item: small delays keep heads coming due; ticks and dispatches
  // carry random junk in the add-only fields.
  function automatic in_t rand_item();
    int   r;
    in_t  it;
    r = $urandom_range(99);
    it = make_item(KIND_ADD, 8'($urandom_range(255)), 16'($urandom), 16'($urandom));
    if (r >= 96)      it.kind = KIND_SPARE;
    else if (r >= 70) it.kind = KIND_DISPATCH;
    else if (r >= 38) it.kind = KIND_TICK;
    else begin
      r = $urandom_range(99);
      if (r < 85)      it.start_delay = 16'($urandom_range(6));
      else if (r < 97) it.start_delay = 16'($urandom_range(40));
      r = $urandom_range(99);
      if (r < 88)      it.period = '0;
      else if (r < 97) it.period = 16'($urandom_range(1, 5));
    end
    return it;
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until the transfer happens. start stays
  // high afterwards so a following item goes out without a bubble.
  task automatic send(in_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start between items, with junk on the data bus meanwhile; n is the gap.
  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= in_t'($bits(in_t)'({$urandom, $urandom}));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every predicted answer has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: dispatch finds nothing, tick does nothing.
    send(make_item(KIND_DISPATCH, 8'h5A, 16'hFFFF, 16'hFFFF));
    send(make_item(KIND_TICK, 8'hA5, 16'h1234, 16'hFFFF));
    idle(2);
    // The ignored kind answers all zeros.
    send(make_item(KIND_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF));
    // Due-now one-shot: nothing pending until the first tick.
    send(make_item(KIND_ADD, 8'h00, 16'h0000, 16'h0000));
    send(make_item(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    idle(1);
    send(make_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    send(make_item(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    // Largest id, delay and period, then fill the list in front of it.
    send(make_item(KIND_ADD, 8'hFF, 16'hFFFF, 16'hFFFF));
    send(make_item(KIND_ADD, 8'h01, 16'h0000, 16'h0000));
    for (int k = 2; k < MAX_TASKS; k++) begin
      send(make_item(KIND_ADD, k[7:0], 16'(k - 2), (k % 4 == 0) ? 16'(k) : 16'h0));
      idle(k % 3);
    end
    // Full list rejects the add.
    send(make_item(KIND_ADD, 8'hAA, 16'h0001, 16'h0002));
    // Head comes due and is dispatched; the new head has nothing pending.
    send(make_item(KIND_TICK, 8'h00, 16'h0000, 16'h0000));
    send(make_item(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    send(make_item(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    drain();

    // Long tick burst on a due one-shot head: pending must stick at 255.
    for (int k = 0; k < 270; k++) begin
      send(make_item(KIND_TICK, 8'($urandom_range(255)), 16'($urandom),
                     16'($urandom)));
      if (k % 50 == 49) idle(pick_gap());
    end
    send(make_item(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000));
    drain();

    // Random traffic, with gap-free stretches and one full drain partway through.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      send(rand_item());
      if (n % 64 >= 16) idle(pick_gap());
      if (n % 150 == 149) drain();
    end

    drain();
    repeat (MAX_TASKS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== delta_list_task_scheduler.f =====
sv/dlts_pkg.sv
sv/dlts_ram.sv
sv/delta_list_task_scheduler.sv
verif/sched_scoreboard.sv
verif/tb_top.sv
